[rtl/core/edge_interval_sensor_frame_decoder_macros.svh]
// Assertion macros for the single-wire sensor frame decoder.
// Included by the top level; depends on nothing else.
`ifndef EDGE_INTERVAL_SENSOR_FRAME_DECODER_MACROS_SVH
`define EDGE_INTERVAL_SENSOR_FRAME_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define EISFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define EISFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EISFD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define EISFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/eisfd_pkg.sv]
// Shared types, constants and the sign-magnitude decoder for the
// single-wire sensor frame decoder. Depends on nothing.
package eisfd_pkg;

  localparam int CAP_W        = 16;
  localparam int VALUE_W      = 16;
  localparam int CNT_W        = 6;
  localparam int FRAME_BITS   = 40;
  localparam int BYTE_W       = 8;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 2 * VALUE_W;

  localparam logic [CNT_W-1:0] PREAMBLE_EDGES = CNT_W'(2);
  localparam logic [CNT_W-1:0] EDGE_SAT       = CNT_W'(63);
  localparam logic [CNT_W-1:0] LAST_BIT       = CNT_W'(FRAME_BITS - 1);
  localparam logic [CAP_W-1:0] THRESHOLD_RESET = CAP_W'(8400);

  // Item kinds carried on the input tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  typedef struct packed {
    logic                      checksum_ok;
    logic signed [VALUE_W-1:0] temperature_tenths;
    logic signed [VALUE_W-1:0] humidity_tenths;
  } result_t;

  // Sign-magnitude high/low byte pair to two's complement. A set top bit of
  // the high byte marks the value negative; negative zero comes out as zero.
  function automatic logic [VALUE_W-1:0] decode_tenths(input logic [BYTE_W-1:0] hi,
                                                      input logic [BYTE_W-1:0] lo);
    logic [VALUE_W-1:0] mag;
    mag = {1'b0, hi[BYTE_W-2:0], lo};
    if (hi[BYTE_W-1]) begin
      return VALUE_W'(0) - mag;
    end
    return mag;
  endfunction

endpackage

[rtl/core/edge_interval_sensor_frame_decoder.sv]
// Single-wire humidity/temperature sensor frame decoder, top level.
// The edge transaction that ends a frame loads its result into the output or skid register.
// One input item per cycle unless the skid register is full; each is handled combinationally.
// A skid register behind the output register keeps input flowing while a result waits.
// Reset (rst, synchronous, active high) idles the receiver, empties both output stages,
// sets the threshold to 8400 ticks and clears the capture, frame and held values.
`include "edge_interval_sensor_frame_decoder_macros.svh"

module edge_interval_sensor_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration: one_bit_threshold_ticks, written when cfg_we is high.
  input  logic                               cfg_we,
  input  logic [eisfd_pkg::CAP_W-1:0]        cfg_wdata,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [eisfd_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] capture_value
  input  logic                               s_tuser,   // [0] opcode
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [eisfd_pkg::OUT_DATA_W-1:0]   m_tdata,   // [15:0] humidity_tenths,
                                                        // [31:16] temperature_tenths
  output logic                               m_tuser    // [0] checksum_ok
);

  import eisfd_pkg::*;

  // Configuration register.
  logic [CAP_W-1:0] threshold;

  // Receiver state.
  logic [CAP_W-1:0]      previous_capture;
  logic [CNT_W-1:0]      edge_counter;
  logic [CNT_W-1:0]      bits_received;
  logic                  receiving;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [VALUE_W-1:0]    held_humidity;
  logic [VALUE_W-1:0]    held_temperature;

  // Output register and the skid register behind it.
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  // Next values of the receiver, computed from the state and the current item.
  logic [CAP_W-1:0]      previous_capture_next;
  logic [CNT_W-1:0]      edge_counter_next;
  logic [CNT_W-1:0]      bits_received_next;
  logic                  receiving_next;
  logic [FRAME_BITS-1:0] frame_shift_next;
  logic [VALUE_W-1:0]    held_humidity_next;
  logic [VALUE_W-1:0]    held_temperature_next;

  logic                  accept;
  logic                  take_out;
  logic                  result_valid;
  result_t               result;
  logic [CAP_W-1:0]      interval;
  logic                  data_bit;
  logic [FRAME_BITS-1:0] shifted;
  logic [BYTE_W-1:0]     byte_sum;
  logic                  sum_ok;

  // The input stalls only when the skid register is occupied, which means the
  // output register is full as well and the downstream side has stalled.
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take_out = out_valid && m_tready;

  // The interval is modulo 2^16, so a timer wrap between successive edges is handled
  // by the plain 16-bit difference. Equal captures give an interval of zero.
  assign interval = s_tdata - previous_capture;
  assign data_bit = (interval > threshold);
  assign shifted  = {frame_shift[FRAME_BITS-2:0], data_bit};

  // Byte-sum checksum over the frame as it stands after this bit: the first four
  // bytes, most significant first, must add up modulo 256 to the fifth.
  assign byte_sum = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];
  assign sum_ok   = (byte_sum == shifted[7:0]);

  always_comb begin
    previous_capture_next = previous_capture;
    edge_counter_next     = edge_counter;
    bits_received_next    = bits_received;
    receiving_next        = receiving;
    frame_shift_next      = frame_shift;
    held_humidity_next    = held_humidity;
    held_temperature_next = held_temperature;
    result_valid          = 1'b0;

    if (accept) begin
      if (s_tuser == OP_START) begin
        // Start (or restart) a frame; the last capture is kept.
        frame_shift_next   = '0;
        bits_received_next = '0;
        edge_counter_next  = '0;
        receiving_next     = 1'b1;
      end else if (receiving) begin
        // Edges while idle leave everything untouched.
        if (edge_counter != EDGE_SAT) begin
          edge_counter_next = edge_counter + CNT_W'(1);
        end
        previous_capture_next = s_tdata;

        if (edge_counter_next <= PREAMBLE_EDGES) begin
          // The two preamble edges only set the timing reference.
          bits_received_next = '0;
        end else begin
          frame_shift_next   = shifted;
          bits_received_next = bits_received + CNT_W'(1);
          if (bits_received == LAST_BIT) begin
            // Fortieth bit: the frame is complete and reception stops.
            receiving_next     = 1'b0;
            bits_received_next = '0;
            result_valid       = 1'b1;
            if (sum_ok) begin
              held_humidity_next    = decode_tenths(shifted[39:32], shifted[31:24]);
              held_temperature_next = decode_tenths(shifted[23:16], shifted[15:8]);
            end
          end
        end
      end
    end
  end

  // The result reports the held values after any update from this frame.
  always_comb begin
    result.checksum_ok        = sum_ok;
    result.humidity_tenths    = held_humidity_next;
    result.temperature_tenths = held_temperature_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= THRESHOLD_RESET;
      previous_capture <= '0;
      edge_counter     <= '0;
      bits_received    <= '0;
      receiving        <= 1'b0;
      frame_shift      <= '0;
      held_humidity    <= '0;
      held_temperature <= '0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      previous_capture <= previous_capture_next;
      edge_counter     <= edge_counter_next;
      bits_received    <= bits_received_next;
      receiving        <= receiving_next;
      frame_shift      <= frame_shift_next;
      held_humidity    <= held_humidity_next;
      held_temperature <= held_temperature_next;
    end
  end

  // Output staging. A new result goes to the output register when it is empty
  // or being drained this cycle, and otherwise parks in the skid register. The
  // skid register is refilled only after it has moved forward, because the
  // input is held off while it is occupied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || take_out) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= result_valid;
          if (result_valid) begin
            out_data <= result;
          end
        end
      end else if (result_valid) begin
        skid_valid <= 1'b1;
        skid_data  <= result;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_data.checksum_ok;
  assign m_tdata  = {out_data.temperature_tenths, out_data.humidity_tenths};

  // The skid register only ever holds a result behind a full output register.
  `EISFD_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid without output")

  // An idle receiver always has an empty bit count.
  `EISFD_ASSERT_SAME(a_idle_no_bits, clk, rst, !receiving, bits_received == '0, "bits while idle")

  // A completed frame stops reception and offers a result.
  `EISFD_ASSERT_NEXT(a_frame_done, clk, rst, result_valid, !receiving && m_tvalid, "frame end lost")

  // A start transaction arms reception with an empty frame.
  `EISFD_ASSERT_NEXT(a_start_arms, clk, rst, accept && s_tuser == OP_START,
                     receiving && bits_received == '0 && edge_counter == '0, "start not armed")

endmodule
